// ----- hw/rtl/lbp_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU buffer pool package
// Shared sizes, payload types and the structs that pass between the control
// logic and the slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

   // Pool geometry and tag widths
   localparam int SLOTS           = 16;
   localparam int SLOT_BITS       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FILE_ID_BITS    = 8;
   localparam int BLOCK_NUM_BITS  = 16;
   localparam int SLOT_FIELD_BITS = 4;
   localparam int WIDE_BITS       = (SLOT_BITS > SLOT_FIELD_BITS) ? SLOT_BITS : SLOT_FIELD_BITS;

   // Rank held by the least recent slot (ranks form a permutation)
   localparam logic [SLOT_BITS-1:0] LRU_RANK = SLOT_BITS'(SLOTS - 1);

   typedef enum logic {
      FUNC_ACCESS = 1'b0,
      FUNC_MARK   = 1'b1
   } func_type;

   typedef struct packed {
      func_type                   func;
      logic [FILE_ID_BITS-1:0]    file_id;
      logic [BLOCK_NUM_BITS-1:0]  block_number;
      logic [SLOT_FIELD_BITS-1:0] target_slot;
   } req_type;

   typedef struct packed {
      logic                       hit;
      logic [SLOT_FIELD_BITS-1:0] slot;
      logic                       load_needed;
      logic                       writeback;
      logic [FILE_ID_BITS-1:0]    wb_file_id;
      logic [BLOCK_NUM_BITS-1:0]  wb_block_number;
   } rsp_type;

   // Request broadcast to every cell during the lookup cycle
   typedef struct packed {
      logic                      is_access;
      logic [FILE_ID_BITS-1:0]   file_id;
      logic [BLOCK_NUM_BITS-1:0] block_number;
      logic [SLOT_BITS-1:0]      mark_slot;
      logic                      mark_ok;
   } lookup_type;

   // Search results accumulated from cell to cell
   typedef struct packed {
      logic                      hit;
      logic [SLOT_BITS-1:0]      hit_slot;
      logic [SLOT_BITS-1:0]      hit_rank;
      logic                      free;
      logic [SLOT_BITS-1:0]      free_slot;
      logic [SLOT_BITS-1:0]      free_rank;
      logic [SLOT_BITS-1:0]      lru_slot;
      logic                      lru_dirty;
      logic [FILE_ID_BITS-1:0]   lru_file_id;
      logic [BLOCK_NUM_BITS-1:0] lru_block_number;
      logic                      mark_valid;
   } chain_type;

   // Update command broadcast to every cell during the update cycle
   typedef struct packed {
      logic                      en;
      logic                      is_access;
      logic                      mark_set;
      logic                      load;
      logic [SLOT_BITS-1:0]      slot;
      logic [SLOT_BITS-1:0]      old_rank;
      logic [FILE_ID_BITS-1:0]   file_id;
      logic [BLOCK_NUM_BITS-1:0] block_number;
   } update_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lbp_if.sv -----
// ----------------------------------------------------------------------------
// LRU buffer pool channels
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbp_req_if;
   logic             valid;
   logic             ready;
   lbp_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lbp_rsp_if;
   logic             valid;
   logic             ready;
   lbp_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lru_buffer_pool_top.sv -----
// ----------------------------------------------------------------------------
// LRU buffer pool top level
// Fully associative page slot pool with least-recently-used replacement and
// dirty writeback reporting, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction. An access
// (func 0) looks up the file id and block number among the valid slots; a hit
// makes that slot most recent, a miss takes the lowest free slot or else evicts
// the least recent one, reporting its tags for writeback if it was dirty, and
// asks for a load. A mark (func 1) sets the dirty bit of a valid target slot
// and reports in hit whether the slot was valid; marks of free or out-of-range
// slots change nothing. Every slot lives in its own cell; during the lookup
// cycle the search results ripple from cell 0 to the last cell, and during the
// update cycle the decision is broadcast back to all cells. A transaction thus
// passes through lookup and update, and the response is registered at the end
// of the update cycle; a new request is taken in that same update cycle while
// the response side keeps up. A response waiting to be taken does not block
// the next request from entering its lookup; only the update stalls until the
// response register is free. Reset leaves all slots free and clean with ranks
// in slot order and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_buffer_pool_top (
   input  wire logic  clock,
   input  wire logic  reset,
   lbp_req_if.sink    req_chan,
   lbp_rsp_if.source  rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic                          is_access;
      logic                          mark_set;
      logic                          load;
      logic [lbp_pkg::SLOT_BITS-1:0] slot;
      logic [lbp_pkg::SLOT_BITS-1:0] old_rank;
      lbp_pkg::rsp_type              rsp;
   } decision_type;

   state_type            state_ff;
   lbp_pkg::req_type     req_ff;
   decision_type         dec_ff, dec_in;
   logic                 rsp_valid_ff;
   lbp_pkg::rsp_type     rsp_data_ff;

   lbp_pkg::lookup_type  lkp;
   lbp_pkg::update_type  upd;
   lbp_pkg::chain_type   chain [lbp_pkg::SLOTS+1];
   lbp_pkg::chain_type   tail;

   logic                         out_free;
   logic                         req_take;
   logic                         do_update;
   logic [lbp_pkg::WIDE_BITS-1:0] tgt_wide;
   logic [lbp_pkg::WIDE_BITS-1:0] chosen_wide;

   // Hold the response register until taken; free it when taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign do_update = (state_ff == S_UPDATE) && out_free;
   assign req_chan.ready = !reset && ((state_ff == S_IDLE) || do_update);
   assign req_take  = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Broadcast the held request to the cells
   assign tgt_wide = lbp_pkg::WIDE_BITS'(req_ff.target_slot);
   always_comb begin
      lkp.is_access    = (req_ff.func == lbp_pkg::FUNC_ACCESS);
      lkp.file_id      = req_ff.file_id;
      lkp.block_number = req_ff.block_number;
      lkp.mark_slot    = tgt_wide[lbp_pkg::SLOT_BITS-1:0];
      lkp.mark_ok      = 32'(req_ff.target_slot) < 32'(lbp_pkg::SLOTS);
   end

   // Cell chain: search results enter empty at cell 0
   assign chain[0] = '0;
   for (genvar i = 0; i < lbp_pkg::SLOTS; i++) begin : g_cell
      lbp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (lbp_pkg::SLOT_BITS'(i)),
         .lkp       (lkp),
         .upd       (upd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end
   assign tail = chain[lbp_pkg::SLOTS];

   // Decide from the chain tail: on an access hit, else lowest free, else evict LRU; on a mark, the target slot
   always_comb begin
      dec_in           = '0;
      dec_in.is_access = lkp.is_access;
      if (lkp.is_access) begin
         if (tail.hit) begin
            dec_in.slot     = tail.hit_slot;
            dec_in.old_rank = tail.hit_rank;
            dec_in.rsp.hit  = 1'b1;
         end else if (tail.free) begin
            dec_in.slot     = tail.free_slot;
            dec_in.old_rank = tail.free_rank;
            dec_in.load     = 1'b1;
         end else begin
            dec_in.slot     = tail.lru_slot;
            dec_in.old_rank = lbp_pkg::LRU_RANK;
            dec_in.load     = 1'b1;
            if (tail.lru_dirty) begin
               dec_in.rsp.writeback       = 1'b1;
               dec_in.rsp.wb_file_id      = tail.lru_file_id;
               dec_in.rsp.wb_block_number = tail.lru_block_number;
            end
         end
         chosen_wide            = lbp_pkg::WIDE_BITS'(dec_in.slot);
         dec_in.rsp.slot        = chosen_wide[lbp_pkg::SLOT_FIELD_BITS-1:0];
         dec_in.rsp.load_needed = dec_in.load;
      end else begin
         chosen_wide     = tgt_wide;
         dec_in.slot     = lkp.mark_slot;
         dec_in.mark_set = tail.mark_valid;
         dec_in.rsp.hit  = tail.mark_valid;
         dec_in.rsp.slot = req_ff.target_slot;
      end
   end

   // Broadcast the registered decision back to the cells
   always_comb begin
      upd.en           = do_update;
      upd.is_access    = dec_ff.is_access;
      upd.mark_set     = dec_ff.mark_set;
      upd.load         = dec_ff.load;
      upd.slot         = dec_ff.slot;
      upd.old_rank     = dec_ff.old_rank;
      upd.file_id      = req_ff.file_id;
      upd.block_number = req_ff.block_number;
   end

   // Sequencer with registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Load a new response, else drop the one taken this cycle
         if (do_update) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               if (do_update) begin
                  state_ff <= req_take ? S_LOOKUP : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Payload registers: advance the request, decision and response
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_chan.data;
      end
      if (state_ff == S_LOOKUP) begin
         dec_ff <= dec_in;
      end
      if (do_update) begin
         rsp_data_ff <= dec_ff.rsp;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lbp_cell.sv -----
// ----------------------------------------------------------------------------
// LRU buffer pool slot cell
// Holds one slot's tags, valid, dirty and recency rank; adds its part to the
// search results passing along the chain and applies broadcast updates.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lbp_pkg::SLOT_BITS-1:0] cell_idx,
   input  wire lbp_pkg::lookup_type           lkp,
   input  wire lbp_pkg::update_type           upd,
   input  wire lbp_pkg::chain_type            chain_in,
   output lbp_pkg::chain_type                 chain_out
);

   logic                               valid_ff, valid_in;
   logic                               dirty_ff, dirty_in;
   logic [lbp_pkg::SLOT_BITS-1:0]      rank_ff, rank_in;
   logic [lbp_pkg::FILE_ID_BITS-1:0]   file_ff;
   logic [lbp_pkg::BLOCK_NUM_BITS-1:0] block_ff;
   logic                               match;
   logic                               chosen;

   // Search: add this slot's contribution to the chain
   always_comb begin
      chain_out = chain_in;
      match = lkp.is_access && valid_ff && (file_ff == lkp.file_id)
              && (block_ff == lkp.block_number);
      if (match) begin
         chain_out.hit      = 1'b1;
         chain_out.hit_slot = cell_idx;
         chain_out.hit_rank = rank_ff;
      end
      if (!valid_ff && !chain_in.free) begin
         chain_out.free      = 1'b1;
         chain_out.free_slot = cell_idx;
         chain_out.free_rank = rank_ff;
      end
      if (rank_ff == lbp_pkg::LRU_RANK) begin
         chain_out.lru_slot         = cell_idx;
         chain_out.lru_dirty        = dirty_ff;
         chain_out.lru_file_id      = file_ff;
         chain_out.lru_block_number = block_ff;
      end
      if (!lkp.is_access && lkp.mark_ok && (cell_idx == lkp.mark_slot) && valid_ff) begin
         chain_out.mark_valid = 1'b1;
      end
   end

   // Update: promote the chosen slot (retagging it on a load) and age the more recent ones, or set dirty on a mark
   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      rank_in  = rank_ff;
      chosen   = (cell_idx == upd.slot);
      if (upd.en) begin
         if (upd.is_access) begin
            if (chosen) begin
               rank_in = '0;
               if (upd.load) begin
                  valid_in = 1'b1;
                  dirty_in = 1'b0;
               end
            end else if (rank_ff < upd.old_rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end else if (upd.mark_set && chosen) begin
            dirty_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         rank_ff  <= cell_idx;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en && upd.is_access && upd.load && chosen) begin
         file_ff  <= upd.file_id;
         block_ff <= upd.block_number;
      end
   end

endmodule

`default_nettype wire

// ----- sim/lru_buffer_pool_top_test.sv -----
// ----------------------------------------------------------------------------
// LRU buffer pool testbench
// Drives access and mark transactions into the pool with random bursts and
// gaps. An internal replica of the slot tags, dirty bits and recency ranks
// predicts each response. The responses are taken under a random stall
// pattern, with long hold-offs, and are checked field by field.
// ----------------------------------------------------------------------------
module lru_buffer_pool_top_test;
   import lbp_pkg::*;

   localparam int TOTAL_REQS   = 1450;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock;
   logic reset;

   lbp_req_if req_chan ();
   lbp_rsp_if rsp_chan ();

   lru_buffer_pool_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Pending request transactions and the responses they must produce
   req_type pending_reqs [$];
   rsp_type expected_rsps [$];

   // Replica of the pool: slot tags, state bits and recency (rank 0 = newest)
   logic                      pool_valid [SLOTS];
   logic                      pool_dirty [SLOTS];
   logic [FILE_ID_BITS-1:0]   pool_file  [SLOTS];
   logic [BLOCK_NUM_BITS-1:0] pool_block [SLOTS];
   logic [SLOT_BITS-1:0]      pool_rank  [SLOTS];

   int unsigned cycle_count = 0;
   int          fail_count = 0;
   int          accepted_count = 0;
   int          hit_count = 0;
   int          load_count = 0;
   int          writeback_count = 0;
   int          mark_count = 0;
   int          mark_free_count = 0;
   int          response_count = 0;

   logic req_took = 1'b0;
   logic hold_rsp = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   stall_mode = 0;

   // Free-running clock, period 12
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Empty the pool: every slot free and clean, ranks in slot order
   task automatic pool_clear();
      for (int i = 0; i < SLOTS; i++) begin
         pool_valid[i] = 1'b0;
         pool_dirty[i] = 1'b0;
         pool_file[i]  = '0;
         pool_block[i] = '0;
         pool_rank[i]  = SLOT_BITS'(i);
      end
   endtask

   // Apply one request to the replica and return the response it yields
   function automatic rsp_type pool_access(input req_type r);
      rsp_type              rsp;
      int                   s;
      logic [SLOT_BITS-1:0] old_rank;
      rsp = '0;
      if (r.func == FUNC_MARK) begin
         // Mark: set dirty only on a valid slot; recency is left alone
         rsp.slot = r.target_slot;
         if (r.target_slot < SLOTS && pool_valid[r.target_slot]) begin
            pool_dirty[r.target_slot] = 1'b1;
            rsp.hit = 1'b1;
         end
      end else begin
         s = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (s < 0 && pool_valid[i] && pool_file[i] == r.file_id &&
                pool_block[i] == r.block_number) begin
               s = i;
            end
         end
         if (s >= 0) begin
            rsp.hit = 1'b1;
         end else begin
            // Miss: lowest free slot first, else the least recent one
            for (int i = 0; i < SLOTS; i++) begin
               if (s < 0 && !pool_valid[i]) begin
                  s = i;
               end
            end
            if (s < 0) begin
               s = 0;
               for (int i = 1; i < SLOTS; i++) begin
                  if (pool_rank[i] > pool_rank[s]) begin
                     s = i;
                  end
               end
               if (pool_dirty[s]) begin
                  rsp.writeback       = 1'b1;
                  rsp.wb_file_id      = pool_file[s];
                  rsp.wb_block_number = pool_block[s];
               end
            end
            pool_valid[s]   = 1'b1;
            pool_dirty[s]   = 1'b0;
            pool_file[s]    = r.file_id;
            pool_block[s]   = r.block_number;
            rsp.load_needed = 1'b1;
         end
         // Promote the slot: everything newer than it ages by one
         old_rank = pool_rank[s];
         for (int j = 0; j < SLOTS; j++) begin
            if (pool_rank[j] < old_rank) begin
               pool_rank[j] = pool_rank[j] + 1'b1;
            end
         end
         pool_rank[s] = '0;
         rsp.slot = SLOT_FIELD_BITS'(s);
      end
      return rsp;
   endfunction

   // Queue an access; the unused target slot carries random noise
   task automatic push_access(input logic [FILE_ID_BITS-1:0]   fid,
                              input logic [BLOCK_NUM_BITS-1:0] blk);
      req_type item;
      item.func         = FUNC_ACCESS;
      item.file_id      = fid;
      item.block_number = blk;
      item.target_slot  = SLOT_FIELD_BITS'($urandom);
      pending_reqs.push_back(item);
   endtask

   // Queue a mark; the unused tag fields carry random noise
   task automatic push_mark(input logic [SLOT_FIELD_BITS-1:0] target);
      req_type item;
      item.func         = FUNC_MARK;
      item.file_id      = FILE_ID_BITS'($urandom);
      item.block_number = BLOCK_NUM_BITS'($urandom);
      item.target_slot  = target;
      pending_reqs.push_back(item);
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // Stimulus: directed opening, random working-set phases, then drain
   initial begin
      logic [FILE_ID_BITS-1:0]   ws_file  [64];
      logic [BLOCK_NUM_BITS-1:0] ws_block [64];
      int                        set_size;
      int                        phase_len;
      int                        roll;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data      = '0;
      rsp_chan.ready     = 1'b0;
      pool_clear();

      // Mark free slots at both ends: nothing changes, hit stays low
      push_mark('0);
      push_mark('1);
      // Extreme tags: all zero, then all ones, then a hit on the first
      push_access('0, '0);
      push_access('1, '1);
      push_access('0, '0);
      // Dirty both slots so that their evictions report writebacks
      push_mark(SLOT_FIELD_BITS'(0));
      push_mark(SLOT_FIELD_BITS'(1));
      // Fill the rest of the pool in slot order
      for (int i = 2; i < SLOTS; i++) begin
         push_access(FILE_ID_BITS'(i), BLOCK_NUM_BITS'(16'h0100 * i));
      end
      // Full pool: evict slot 1 (all-ones tags), then slot 0 (zero tags)
      push_access(8'hA5, 16'h5A5A);
      push_access(8'h5A, 16'hA5A5);
      // Mark a valid slot, then hit it again
      push_mark(SLOT_FIELD_BITS'(SLOTS - 1));
      push_access(FILE_ID_BITS'(SLOTS - 1), BLOCK_NUM_BITS'(16'h0100 * (SLOTS - 1)));

      // Random phases: each draws a working set sized to hit or thrash the pool
      while (pending_reqs.size() < TOTAL_REQS) begin
         case ($urandom_range(0, 3))
            0: set_size = 6;
            1: set_size = SLOTS - 2;
            2: set_size = SLOTS + 4;
            default: set_size = 48;
         endcase
         for (int k = 0; k < set_size; k++) begin
            ws_file[k]  = FILE_ID_BITS'($urandom);
            ws_block[k] = BLOCK_NUM_BITS'($urandom);
            if ($urandom_range(0, 7) == 0) begin
               ws_file[k] = $urandom_range(0, 1) ? '1 : '0;
            end
            if ($urandom_range(0, 7) == 0) begin
               ws_block[k] = $urandom_range(0, 1) ? '1 : '0;
            end
         end
         phase_len = $urandom_range(60, 140);
         for (int n = 0; n < phase_len && pending_reqs.size() < TOTAL_REQS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
               push_mark(SLOT_FIELD_BITS'($urandom));
            end else if (roll < 30) begin
               push_access(FILE_ID_BITS'($urandom), BLOCK_NUM_BITS'($urandom));
            end else begin
               roll = $urandom_range(0, set_size - 1);
               push_access(ws_file[roll], ws_block[roll]);
            end
         end
      end

      // Hold reset, then release it at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for every transaction to go in and every response to come out
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests, %0d responses, %0d hits, %0d loads, %0d writebacks",
               accepted_count, response_count, hit_count, load_count, writeback_count);
      $display("summary: %0d marks, %0d of them on free slots", mark_count, mark_free_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: end the run if it outlives any plausible correct run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("tb: failure");
      $finish;
   end

   // Request driver: hold an offered transaction until taken, else advance
   // through bursts and gaps
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_took) begin
         // Hold: the current transaction has not been accepted yet
      end else if (gap_left > 0) begin
         gap_left--;
         req_chan.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         req_chan.valid <= 1'b1;
         req_chan.data  <= pending_reqs[0];
         if (burst_left > 0) begin
            burst_left--;
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Request acceptance: predict the response and drop the pending entry
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && req_chan.valid && req_chan.ready) begin
         exp_rsp = pool_access(req_chan.data);
         expected_rsps.push_back(exp_rsp);
         void'(pending_reqs.pop_front());
         accepted_count++;
         if (req_chan.data.func == FUNC_MARK) begin
            mark_count++;
            if (!exp_rsp.hit) begin
               mark_free_count++;
            end
         end else begin
            if (exp_rsp.hit) begin
               hit_count++;
            end
            if (exp_rsp.load_needed) begin
               load_count++;
            end
            if (exp_rsp.writeback) begin
               writeback_count++;
            end
         end
         req_took <= 1'b1;
      end else begin
         req_took <= 1'b0;
      end
   end

   // Long hold-offs: stop taking responses for a stretch while requests keep
   // coming, so the pool backs up and drops its request ready
   initial begin
      while (accepted_count < 400) begin
         @(negedge clock);
      end
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp <= 1'b0;
      while (accepted_count < 1000) begin
         @(negedge clock);
      end
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   // Response ready: switch among random stall patterns
   always @(negedge clock) begin
      if (cycle_count % 50 == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      if (reset || hold_rsp) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: rsp_chan.ready <= (cycle_count % 5 < 3);
         endcase
      end
   end

   // Response monitor: compare each accepted transaction with the oldest
   // expected response
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         response_count++;
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: slot 0x%0h", rsp_chan.data.slot);
            fail_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            compare_field("hit", 32'(exp_rsp.hit), 32'(rsp_chan.data.hit));
            compare_field("slot", 32'(exp_rsp.slot), 32'(rsp_chan.data.slot));
            compare_field("load_needed", 32'(exp_rsp.load_needed),
                          32'(rsp_chan.data.load_needed));
            compare_field("writeback", 32'(exp_rsp.writeback),
                          32'(rsp_chan.data.writeback));
            compare_field("wb_file_id", 32'(exp_rsp.wb_file_id),
                          32'(rsp_chan.data.wb_file_id));
            compare_field("wb_block_number", 32'(exp_rsp.wb_block_number),
                          32'(rsp_chan.data.wb_block_number));
         end
      end
   end

endmodule
